FILE: rtl/core/srt_pkg.sv
// Shared types and constants for the sorted region table.
package srt_pkg;
	localparam int MaxRegionsDef = 16;
	localparam int AddrBitsDef = 32;
	localparam int PageBitsDef = 12;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND = 2'd1,
		OP_FREE = 2'd2,
		OP_NONE = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT,
		S_WRITE,
		S_HITRD,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0] op;
		logic [31:0] addr;
		logic [31:0] length;
		logic [2:0] region_type;
		logic [15:0] region_attr;
		logic [31:0] search_low;
		logic [31:0] search_high;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [3:0] hit_index;
		logic [31:0] hit_start;
		logic [31:0] hit_end;
		logic [2:0] hit_type;
		logic [15:0] hit_attr;
		logic [31:0] free_base;
	} rsp_t;
endpackage

FILE: rtl/core/srt_if.sv
// Valid/ready channel interface carrying one payload per beat.
interface srt_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/srt_ram.sv
// Generic RAM with one write port and one registered read port.
module srt_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

FILE: rtl/core/sorted_region_table.sv
// Sorted region table: insert, find and first-fit free search over one entry RAM.
//
// Channels: req (sink) carries one operation per beat; rsp (source) returns
// exactly one result beat per request, in order.
// Each entry (start, end, type, attr) lives in one synchronous RAM word; the
// control walks the table in order, an address step then a compare per entry.
// Find stops at the first entry holding the address; find-free skips entries
// ending at or below its start and compares the first entry past it again;
// insert scans, moves the entries from the slot up by one, writes, reads back.
// A full insert or an unused op goes straight to the result.
// The RAM has a single port pair, one read and one write a cycle.
// One operation is in flight at a time; the next request is taken while the
// previous result still waits in the output register, and that operation then
// holds in its last state until the receiver takes the waiting beat.
// Reset (arst_n low) empties the table: the entry count goes to zero and RAM
// contents are never read past the count, so no clearing pass is needed.
// A stalled receiver holds the result beat stable; no work is lost.
module sorted_region_table #(
	parameter int MAX_REGIONS = srt_pkg::MaxRegionsDef,
	parameter int ADDR_BITS = srt_pkg::AddrBitsDef,
	parameter int PAGE_BITS = srt_pkg::PageBitsDef
) (
	input logic clk,
	input logic arst_n,
	srt_if.sink req,
	srt_if.source rsp
);
	import srt_pkg::*;

	localparam int IW = $clog2(MAX_REGIONS);
	localparam int CW = $clog2(MAX_REGIONS + 1);
	localparam int EW = 2 * ADDR_BITS + 3 + 16;
	localparam int XW = ADDR_BITS + 2;
	localparam logic [XW-1:0] AMASK = {2'b0, {ADDR_BITS{1'b1}}};
	localparam logic [XW-1:0] PMASK = XW'((64'd1 << PAGE_BITS) - 64'd1);

	state_t state_q, state_d;
	req_t r_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] idx_q;
	logic [XW-1:0] base_q, end_q, len_q, cand_q, lo_q, hi_q;
	logic [ADDR_BITS-1:0] e_start, e_end;
	logic [2:0] e_type;
	logic [15:0] e_attr;
	logic [EW-1:0] rdata, wdata;
	logic [IW-1:0] raddr, waddr;
	logic we;
	logic rd_ok_q;
	logic mv_ph_q;
	rsp_t res_q, res_d;
	logic res_v_q;
	logic fin;

	srt_ram #(.Width(EW), .Depth(MAX_REGIONS)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	assign {e_start, e_end, e_type, e_attr} = rdata;

	logic [XW-1:0] xs, xe, ealign;
	assign xs = XW'(e_start);
	assign xe = XW'(e_end);
	assign ealign = (xe + PMASK) & ~PMASK;

	logic out_free;
	assign out_free = !res_v_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE);

	// request decode
	logic [XW-1:0] in_a, in_len, in_base, in_lo, in_hi, in_cand;
	always_comb begin
		in_a = XW'(req.payload.addr[ADDR_BITS > 32 ? 31 : ADDR_BITS-1:0]);
		in_len = (XW'(req.payload.length) + PMASK) & ~PMASK;
		in_base = in_a & ~PMASK;
		in_lo = XW'(req.payload.search_low) & AMASK;
		in_hi = XW'(req.payload.search_high) & AMASK;
		in_cand = (in_a != '0) ? in_base : in_lo;
		if (in_cand < in_lo) begin
			in_cand = in_lo;
		end
	end

	logic in_scan; // high while the table is scanned
	logic at_end;
	assign at_end = idx_q >= count_q;

	logic skip_q; // free search: entries ending at or below cand are skipped

	// next state
	always_comb begin
		state_d = state_q;
		fin = 1'b0;
		case (state_q)
			S_IDLE: if (req.valid && req.ready) begin
				state_d = S_SCAN;
				if (op_t'(req.payload.op) == OP_NONE) begin
					state_d = S_DONE;
				end else if (op_t'(req.payload.op) == OP_INSERT && count_q >= CW'(MAX_REGIONS)) begin
					state_d = S_DONE;
				end
			end
			S_SCAN: if (rd_ok_q) begin
				case (op_t'(r_q.op))
					OP_INSERT: if (at_end || xs > base_q) state_d = S_SHIFT;
					OP_FIND: if (at_end || (base_q >= xs && base_q < xe)) state_d = S_DONE;
					default: if (at_end || (!skip_q && (cand_q + len_q <= xs
							|| xe > AMASK - PMASK || ealign + len_q > hi_q))
							|| len_q > hi_q || cand_q > hi_q - len_q)
						state_d = S_DONE;
				endcase
			end else if (op_t'(r_q.op) == OP_FREE && (len_q > hi_q || cand_q > hi_q - len_q)) begin
				state_d = S_DONE;
			end
			S_SHIFT: if (mv_ph_q == 1'b0 && sh_q == idx_q) state_d = S_WRITE;
			S_WRITE: state_d = S_HITRD;
			S_HITRD: state_d = S_DONE;
			S_DONE: if (out_free) begin
				fin = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// shift uses cursor sh_q from count down to idx
	logic [CW-1:0] sh_q;
	assign in_scan = state_q == S_SCAN;

	// memory controls
	always_comb begin
		raddr = IW'(idx_q);
		we = 1'b0;
		waddr = IW'(sh_q);
		wdata = rdata;
		if (state_q == S_SHIFT) begin
			raddr = IW'(sh_q - CW'(1));
			we = mv_ph_q;
		end else if (state_q == S_WRITE) begin
			we = 1'b1;
			waddr = IW'(idx_q);
			wdata = {base_q[ADDR_BITS-1:0], end_q[ADDR_BITS-1:0],
				r_q.region_type, r_q.region_attr};
		end
	end

	// result compose
	always_comb begin
		res_d = '0;
		res_d.status = ST_NOT_FOUND;
		case (op_t'(r_q.op))
			// a full insert never enters the scan
			OP_INSERT: if (!rd_ok_q) begin
				res_d.status = ST_FULL;
			end else begin
				res_d.status = ST_OK;
				res_d.hit_index = idx_q[3 < IW ? 3 : IW-1:0];
				res_d.hit_start = 32'(e_start);
				res_d.hit_end = 32'(e_end);
				res_d.hit_type = e_type;
				res_d.hit_attr = e_attr;
			end
			OP_FIND: if (rd_ok_q && !at_end && base_q >= xs && base_q < xe) begin
				res_d.status = ST_OK;
				res_d.hit_index = idx_q[3 < IW ? 3 : IW-1:0];
				res_d.hit_start = 32'(e_start);
				res_d.hit_end = 32'(e_end);
				res_d.hit_type = e_type;
				res_d.hit_attr = e_attr;
			end
			OP_FREE: if (len_q <= hi_q && cand_q <= hi_q - len_q
					&& (at_end || cand_q + len_q <= xs)) begin
				res_d.status = ST_OK;
				res_d.free_base = 32'(cand_q);
			end
			default: res_d.status = ST_NOT_FOUND;
		endcase
	end

	logic res_ld;
	assign res_ld = state_q == S_DONE && out_free;

	logic cand_step;
	assign cand_step = state_q == S_SCAN && rd_ok_q && state_d == S_SCAN
		&& op_t'(r_q.op) == OP_FREE && !skip_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			res_v_q <= 1'b0;
			rd_ok_q <= 1'b0;
			mv_ph_q <= 1'b0;
			idx_q <= '0;
			sh_q <= '0;
			skip_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_ld) begin
				res_v_q <= 1'b1;
			end else if (rsp.ready) begin
				res_v_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					idx_q <= '0;
					rd_ok_q <= 1'b0;
					skip_q <= 1'b1;
					sh_q <= count_q;
					mv_ph_q <= 1'b0;
				end
				S_SCAN: begin
					if (!rd_ok_q || state_d != S_SCAN) begin
						rd_ok_q <= 1'b1;
					end else if (op_t'(r_q.op) == OP_FREE && skip_q && xe > cand_q) begin
						// first entry past the start: compare it again
						skip_q <= 1'b0;
					end else begin
						rd_ok_q <= 1'b0;
						idx_q <= idx_q + CW'(1);
					end
					if (state_d == S_SHIFT) begin
						sh_q <= count_q;
						mv_ph_q <= 1'b0;
					end
				end
				S_SHIFT: begin
					if (mv_ph_q) begin
						sh_q <= sh_q - CW'(1);
					end
					mv_ph_q <= !mv_ph_q && sh_q != idx_q;
				end
				S_WRITE: count_q <= count_q + CW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			r_q <= req.payload;
			len_q <= in_len;
			lo_q <= in_lo;
			hi_q <= in_hi;
			cand_q <= in_cand;
			base_q <= (op_t'(req.payload.op) == OP_FIND) ? in_a : in_base;
			end_q <= (in_len > AMASK - in_base) ? AMASK : in_base + in_len;
		end else if (cand_step) begin
			cand_q <= ealign;
		end
		if (res_ld) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid = res_v_q;
	assign rsp.payload = res_q;

	logic unused;
	assign unused = ^{lo_q, in_scan, fin};
endmodule
